>>> rtl/motor_power_limiter_defines.svh
// ---------------------------------------------------------------------------
// motor power limiter assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef MOTOR_POWER_LIMITER_DEFINES_SVH
`define MOTOR_POWER_LIMITER_DEFINES_SVH

// implication into the next cycle, masked while reset is asserted
`define MPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpl check failed");

// implication into the next cycle, checked through reset as well
`define MPL_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mpl check failed");

`endif

>>> rtl/mpl_pkg.sv
// ---------------------------------------------------------------------------
// mpl_pkg
// types, constants and coefficient tables of the motor power limiter
// ---------------------------------------------------------------------------
package mpl_pkg;

    localparam logic [14:0] KNEE_RPM        = 15'd5000;
    localparam logic [31:0] EXP_STEP_Q31    = 32'd2146052469;
    localparam logic [16:0] DECAY_FLOOR_Q16 = 17'd66;
    localparam logic [16:0] ONE_Q15         = 17'd32768;
    localparam logic [23:0] REV_FLOOR_Q16   = 24'd196608;
    localparam logic [16:0] FORCE_BELOW_Q15 = 17'd6554;
    localparam logic [16:0] RATIO_MIN_Q15   = 17'd1638;
    localparam logic [16:0] SMOOTH_MIN_Q15  = 17'd328;
    localparam logic [31:0] CAP_FULL_SQ     = 32'd590490000;
    localparam logic signed [15:0] DIR_DEADBAND = 16'sd50;
    localparam logic [4:0]  DECAY_STEPS     = 5'd14;
    localparam logic [4:0]  DIV_STEPS       = 5'd30;
    localparam logic [4:0]  SQRT_STEPS      = 5'd15;
    // ceil(2^35 / 10): exact quotient by 10 (>> 35) or by 20 (>> 36) of 32-bit values
    localparam logic [31:0] RECIP_10        = 32'hCCCC_CCCD;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        MODE_RECOVER,
        MODE_FORCE,
        MODE_LIMIT
    } t_mode;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DEC_ACC, ST_DEC_SQ, ST_DEC_NXT, ST_IE, ST_IE2,
        ST_A1, ST_A2, ST_A3, ST_C1, ST_C2, ST_C3, ST_B1, ST_V1,
        ST_DECIDE, ST_SCALE, ST_DIV, ST_POST, ST_SQRT, ST_RATIO,
        ST_MAG, ST_FIN, ST_OUT
    } t_state;

    function automatic logic [31:0] coef_a(input logic kind);
        return kind ? 32'd2302812 : 32'd2878515;
    endfunction

    function automatic logic [31:0] coef_b(input logic kind);
        return kind ? 32'd6746519 : 32'd44976792;
    endfunction

    function automatic logic [31:0] coef_c(input logic kind);
        return kind ? 32'd259485 : 32'd117648;
    endfunction

    function automatic logic [31:0] coef_d(input logic kind);
        return kind ? 32'd98304 : 32'd85197;
    endfunction

endpackage

>>> rtl/mpl_if.sv
// ---------------------------------------------------------------------------
// mpl channel interfaces
// valid/ready command and result channels of the motor power limiter
// ---------------------------------------------------------------------------
interface mpl_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] target_current;
    logic signed [14:0] shaft_speed;
    logic [15:0]        power_budget;
    logic [14:0]        cap_voltage_mv;
    logic               motor_kind;

    modport source (output valid, target_current, shaft_speed, power_budget,
                    cap_voltage_mv, motor_kind, input ready);
    modport sink   (input valid, target_current, shaft_speed, power_budget,
                    cap_voltage_mv, motor_kind, output ready);
endinterface

interface mpl_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] limited_current;
    logic [15:0]        predicted_power;

    modport source (output valid, limited_current, predicted_power, input ready);
    modport sink   (input valid, limited_current, predicted_power, output ready);
endinterface

>>> rtl/mpl_mul.sv
// ---------------------------------------------------------------------------
// mpl_mul
// shared 32x32 unsigned multiplier with a registered product
// ---------------------------------------------------------------------------
module mpl_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;
endmodule

>>> rtl/motor_power_limiter.sv
// A zero budget skips the computation and goes straight to the output register; the
// next command is taken only once the result is loaded there, after any output stall.
// The time of a command is set by the decay loop on the shared multiplier, the
// 30-step restoring divider and the 15-step square root of the limiting path.
// Reset (synchronous, active low) sets every ratio to 1.0, every direction to none
// and empties the output register.
// ---------------------------------------------------------------------------
// motor_power_limiter
// per-command power prediction and current scaling on one shared multiplier
// ---------------------------------------------------------------------------
module motor_power_limiter #(
    parameter int MOTOR_KINDS = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpl_cmd_if.sink    i_cmd,
    mpl_res_if.source  o_res
);
    import mpl_pkg::*;

    localparam int SLOT_W = (MOTOR_KINDS > 1) ? $clog2(MOTOR_KINDS) : 1;

    t_state r_state, n_state;

    logic [16:0]        r_ratio [MOTOR_KINDS];
    t_dir               r_ldir  [MOTOR_KINDS];

    logic               r_neg;
    logic [15:0]        r_absi;
    logic [14:0]        r_spd;
    logic [14:0]        r_volt;
    logic [15:0]        r_budget;
    logic               r_kind;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_rev;
    logic [13:0]        r_d;
    logic [4:0]         r_cnt;
    logic [31:0]        r_acc;
    logic [31:0]        r_c;
    logic [23:0]        r_ie;
    logic [46:0]        r_t;
    logic [63:0]        r_plo;
    logic [31:0]        r_a;
    logic [31:0]        r_cc;
    logic [31:0]        r_b;
    logic               r_capfull;
    logic [16:0]        r_s;
    t_mode              r_mode;
    logic [32:0]        r_rem;
    logic [29:0]        r_dvd;
    logic [31:0]        r_dvs;
    logic [29:0]        r_quo;
    logic [29:0]        r_sx;
    logic [30:0]        r_sr;
    logic [28:0]        r_sbit;
    logic [15:0]        r_pq;
    logic [15:0]        r_lim;
    logic               r_ovalid;
    logic [15:0]        r_olim;
    logic [15:0]        r_opq;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    mpl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // input decode
    logic               cmd_xfer;
    logic [16:0]        in_abs_i;
    logic [15:0]        in_abs_s;
    t_dir               in_dir;
    logic [SLOT_W-1:0]  in_slot;
    t_dir               old_dir;

    assign cmd_xfer = i_cmd.valid && i_cmd.ready;
    assign in_abs_i = i_cmd.target_current[15] ? 17'(-$signed({i_cmd.target_current[15],
                      i_cmd.target_current})) : 17'(i_cmd.target_current);
    assign in_abs_s = i_cmd.shaft_speed[14] ? 16'(-$signed({i_cmd.shaft_speed[14],
                      i_cmd.shaft_speed})) : 16'(i_cmd.shaft_speed);
    assign in_dir   = (i_cmd.target_current > DIR_DEADBAND) ? DIR_POS :
                      (i_cmd.target_current < -DIR_DEADBAND) ? DIR_NEG : DIR_NONE;
    assign in_slot  = (32'(i_cmd.motor_kind) < MOTOR_KINDS) ? SLOT_W'(i_cmd.motor_kind)
                                                             : SLOT_W'(MOTOR_KINDS - 1);
    assign old_dir  = r_ldir[in_slot];

    // datapath helpers
    logic [31:0] rnd31;
    logic [32:0] dec_sum;
    logic [16:0] dec_q;
    logic [23:0] ie_w;
    logic [31:0] pred;
    logic [23:0] eff;
    logic [23:0] rev_eff;
    logic [31:0] fixed_p, var_p, tv;
    logic [23:0] pq_full;
    logic [32:0] div_sh;
    logic        div_ge;
    logic [30:0] sq_rb;
    logic        sq_ge;
    logic [16:0] tr_c;
    logic [17:0] s_avg;
    logic [16:0] s_lim;
    logic [16:0] mag;
    logic [16:0] rcp_q;

    assign rnd31   = 32'((prod + (64'd1 << 30)) >> 31);
    assign dec_sum = 33'(r_acc) + 33'd16384;
    assign dec_q   = (dec_sum[31:15] < DECAY_FLOOR_Q16) ? DECAY_FLOOR_Q16 : dec_sum[31:15];
    assign ie_w    = 24'((prod + 64'd128) >> 8);
    assign pred    = r_a + r_b + r_cc + coef_d(r_kind);
    assign rev_eff = {3'b0, r_budget, 5'b0};
    assign eff     = r_rev ? ((rev_eff < REV_FLOOR_Q16) ? REV_FLOOR_Q16 : rev_eff)
                           : {r_budget, 8'b0};
    assign pq_full = 24'((pred + 32'd128) >> 8);
    assign fixed_p = r_b + coef_d(r_kind);
    assign var_p   = r_a + r_cc;
    assign tv      = ({8'b0, eff} > fixed_p) ? {8'b0, eff} - fixed_p : 32'd0;
    assign div_sh  = {r_rem[31:0], r_dvd[29]};
    assign div_ge  = div_sh >= {1'b0, r_dvs};
    assign sq_rb   = r_sr + {2'b0, r_sbit};
    assign sq_ge   = {1'b0, r_sx} >= sq_rb;
    assign tr_c    = (r_sr[16:0] > ONE_Q15) ? ONE_Q15 :
                     (r_sr[16:0] < RATIO_MIN_Q15) ? RATIO_MIN_Q15 : r_sr[16:0];
    assign s_avg   = (18'(r_s) + 18'(tr_c) + 18'd1) >> 1;
    assign s_lim   = (s_avg > 18'(ONE_Q15)) ? ONE_Q15 :
                     (s_avg < 18'(SMOOTH_MIN_Q15)) ? SMOOTH_MIN_Q15 : s_avg[16:0];
    assign mag     = 17'((prod + 64'd16384) >> 15);
    // quotient by 20 for forced recovery, by 10 for recovery
    assign rcp_q   = (r_mode == MODE_FORCE) ? prod[52:36] : prod[51:35];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        mul_a   = 32'd0;
        mul_b   = 32'd0;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_xfer) begin
                    n_state = (i_cmd.power_budget == 16'd0) ? ST_OUT : ST_DEC_ACC;
                end
            end
            ST_DEC_ACC: begin
                mul_a   = r_acc;
                mul_b   = r_c;
                n_state = ST_DEC_SQ;
            end
            ST_DEC_SQ: begin
                mul_a   = r_c;
                mul_b   = r_c;
                n_state = ST_DEC_NXT;
            end
            ST_DEC_NXT: begin
                n_state = (r_cnt == DECAY_STEPS - 5'd1) ? ST_IE : ST_DEC_ACC;
            end
            ST_IE: begin
                mul_a   = 32'(r_absi);
                mul_b   = 32'(dec_q);
                n_state = ST_IE2;
            end
            ST_IE2: begin
                mul_a   = 32'(ie_w);
                mul_b   = 32'(r_spd);
                n_state = ST_A1;
            end
            ST_A1: begin
                mul_a   = prod[31:0];
                mul_b   = coef_a(r_kind);
                n_state = ST_A2;
            end
            ST_A2: begin
                mul_a   = 32'(r_t[37:32]);
                mul_b   = coef_a(r_kind);
                n_state = ST_A3;
            end
            ST_A3: begin
                mul_a   = 32'(r_ie);
                mul_b   = 32'(r_ie);
                n_state = ST_C1;
            end
            ST_C1: begin
                mul_a   = prod[31:0];
                mul_b   = coef_c(r_kind);
                n_state = ST_C2;
            end
            ST_C2: begin
                mul_a   = 32'(r_t[46:32]);
                mul_b   = coef_c(r_kind);
                n_state = ST_C3;
            end
            ST_C3: begin
                mul_a   = 32'(r_spd);
                mul_b   = coef_b(r_kind);
                n_state = ST_B1;
            end
            ST_B1: begin
                mul_a   = 32'(r_volt);
                mul_b   = 32'(r_volt);
                n_state = ST_V1;
            end
            ST_V1: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (pred <= {8'b0, eff}) begin
                    mul_a   = 32'(ONE_Q15 - r_s);
                    mul_b   = 32'd7;
                    n_state = ST_SCALE;
                end else if (r_s < FORCE_BELOW_Q15 && r_capfull) begin
                    mul_a   = 32'(r_s);
                    mul_b   = 32'd21;
                    n_state = ST_SCALE;
                end else if (var_p == 32'd0 || tv >= var_p) begin
                    n_state = ST_RATIO;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_SCALE: begin
                // divide the scaled ratio through the reciprocal
                mul_a   = prod[31:0];
                mul_b   = RECIP_10;
                n_state = ST_POST;
            end
            ST_DIV: begin
                n_state = (r_cnt == DIV_STEPS - 5'd1) ? ST_POST : ST_DIV;
            end
            ST_POST: begin
                n_state = (r_mode == MODE_LIMIT) ? ST_SQRT : ST_MAG;
            end
            ST_SQRT: begin
                n_state = (r_cnt == SQRT_STEPS - 5'd1) ? ST_RATIO : ST_SQRT;
            end
            ST_RATIO: begin
                n_state = ST_MAG;
            end
            ST_MAG: begin
                mul_a   = 32'(r_absi);
                mul_b   = 32'(r_s);
                n_state = ST_FIN;
            end
            ST_FIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // per-kind state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOTOR_KINDS; k++) begin
                r_ratio[k] <= ONE_Q15;
                r_ldir[k]  <= DIR_NONE;
            end
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_IDLE && cmd_xfer && i_cmd.power_budget != 16'd0) begin
                r_ldir[in_slot] <= in_dir;
            end
            if (r_state == ST_MAG) begin
                r_ratio[r_slot] <= r_s;
            end
            if (r_state == ST_OUT && (!r_ovalid || o_res.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_neg    <= i_cmd.target_current[15];
                r_absi   <= in_abs_i[15:0];
                r_spd    <= in_abs_s[14:0];
                r_volt   <= i_cmd.cap_voltage_mv;
                r_budget <= i_cmd.power_budget;
                r_kind   <= i_cmd.motor_kind;
                r_slot   <= in_slot;
                r_rev    <= old_dir != DIR_NONE && in_dir != DIR_NONE && old_dir != in_dir;
                r_s      <= (r_ratio[in_slot] > ONE_Q15) ? ONE_Q15 : r_ratio[in_slot];
                r_d      <= (in_abs_s[14:0] > KNEE_RPM) ? 14'(in_abs_s[14:0] - KNEE_RPM)
                                                        : 14'd0;
                r_acc    <= 32'h8000_0000;
                r_c      <= EXP_STEP_Q31;
                r_cnt    <= 5'd0;
                r_lim    <= i_cmd.target_current;
                r_pq     <= 16'd0;
            end
            ST_DEC_SQ: begin
                if (r_d[0]) begin
                    r_acc <= rnd31;
                end
            end
            ST_DEC_NXT: begin
                r_c   <= rnd31;
                r_d   <= r_d >> 1;
                r_cnt <= r_cnt + 5'd1;
            end
            ST_IE2: r_ie <= ie_w;
            ST_A1:  r_t  <= prod[46:0];
            ST_A2:  r_plo <= prod;
            ST_A3:  r_a  <= 32'((r_plo + (prod << 32) + (64'd1 << 31)) >> 32);
            ST_C1:  r_t  <= prod[46:0];
            ST_C2:  r_plo <= prod;
            ST_C3:  r_cc <= 32'((r_plo + (prod << 32) + (64'd1 << 39)) >> 40);
            ST_B1:  r_b  <= 32'((prod + 64'd32768) >> 16);
            ST_V1:  r_capfull <= {prod[30:0], 1'b0} >= CAP_FULL_SQ;
            ST_DECIDE: begin
                r_pq  <= (pq_full > 24'd65535) ? 16'hFFFF : pq_full[15:0];
                r_cnt <= 5'd0;
                r_sr  <= 31'(ONE_Q15);
                if (pred <= {8'b0, eff}) begin
                    r_mode <= MODE_RECOVER;
                end else if (r_s < FORCE_BELOW_Q15 && r_capfull) begin
                    r_mode <= MODE_FORCE;
                end else begin
                    r_mode <= MODE_LIMIT;
                    r_rem  <= 33'(tv);
                    r_dvd  <= 30'd0;
                    r_dvs  <= var_p;
                end
            end
            ST_DIV: begin
                r_rem <= div_ge ? div_sh - {1'b0, r_dvs} : div_sh;
                r_dvd <= r_dvd << 1;
                r_quo <= {r_quo[28:0], div_ge};
                r_cnt <= r_cnt + 5'd1;
            end
            ST_POST: begin
                r_cnt  <= 5'd0;
                r_sx   <= r_quo;
                r_sr   <= 31'd0;
                r_sbit <= 29'h1000_0000;
                case (r_mode)
                    MODE_RECOVER: r_s <= ONE_Q15 - rcp_q;
                    MODE_FORCE:   r_s <= (rcp_q > ONE_Q15) ? ONE_Q15 : rcp_q;
                    default:      r_s <= r_s;
                endcase
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    r_sx <= 30'({1'b0, r_sx} - sq_rb);
                    r_sr <= (r_sr >> 1) + {2'b0, r_sbit};
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
                r_cnt  <= r_cnt + 5'd1;
            end
            ST_RATIO: r_s <= s_lim;
            ST_FIN:   r_lim <= r_neg ? 16'(-mag) : mag[15:0];
            ST_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    r_olim <= r_lim;
                    r_opq  <= r_pq;
                end
            end
            default: ;
        endcase
    end

    assign i_cmd.ready           = (r_state == ST_IDLE);
    assign o_res.valid           = r_ovalid;
    assign o_res.limited_current = r_olim;
    assign o_res.predicted_power = r_opq;

endmodule

>>> rtl/mpl_checker.sv
// ---------------------------------------------------------------------------
// mpl_checker
// port-level checks of the motor power limiter, bound to the top level
// ---------------------------------------------------------------------------
`include "motor_power_limiter_defines.svh"

module mpl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_lim,
    input logic [15:0] i_out_pq
);
    // a command keeps the block busy for at least the following cycle
    `MPL_ASSERT_NEXT(a_busy_after_cmd, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // reset empties the result register
    `MPL_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)
    // a stalled result keeps its valid
    `MPL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // a stalled result keeps its payload
    `MPL_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        $stable(i_out_lim) && $stable(i_out_pq))
endmodule

bind motor_power_limiter mpl_checker u_mpl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_lim   (o_res.limited_current),
    .i_out_pq    (o_res.predicted_power)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor power limiter testbench
// drives motor commands through the valid/ready command channel, predicts
// the scaled current and the predicted power of each command with an
// in-bench model of both motor kinds, and checks every result transfer
// ---------------------------------------------------------------------------
module tb;
    import mpl_pkg::*;

    typedef struct packed {
        logic signed [15:0] current;
        logic [15:0]        power;
    } t_result;

    // power model coefficients per motor kind, scaled to a Q8 watt sum with rpm folded in
    localparam longint unsigned PW_K0 [2] = '{64'd2878515, 64'd2302812};
    localparam longint unsigned PW_K1 [2] = '{64'd44976792, 64'd6746519};
    localparam longint unsigned PW_K2 [2] = '{64'd117648, 64'd259485};
    localparam longint unsigned PW_K3 [2] = '{64'd85197, 64'd98304};
    localparam int unsigned     UNITY = 32768;
    localparam int              STALL_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    mpl_cmd_if cmd ();
    mpl_res_if res ();

    motor_power_limiter #(.MOTOR_KINDS(2)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_res   (res)
    );

    int unsigned ratio_q15 [2];
    t_dir        heading [2];
    t_result     pending_results [$];
    int          mismatches;
    int          commands_sent;
    int          results_checked;
    bit          idling_on;
    int          hold_requests;
    int          idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // exp(-excess/1500) in Q16, floored
    function automatic longint unsigned decay_gain(input int unsigned spd);
        longint unsigned acc;
        longint unsigned step;
        longint unsigned q;
        int unsigned     excess;
        acc  = 64'd1 << 31;
        step = 64'd2146052469;
        if (spd <= 5000) return 64'd65536;
        excess = (spd - 5000) & 32'h3fff;
        for (int i = 0; i < 14; i++) begin
            if (excess[i]) acc = (acc * step + (64'd1 << 30)) >> 31;
            step = (step * step + (64'd1 << 30)) >> 31;
        end
        q = (acc + (64'd1 << 14)) >> 15;
        return (q < 66) ? 64'd66 : q;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // predicts one command's result and advances the per-kind ratio state
    function automatic t_result limit_power(input logic signed [15:0] cur,
                                            input logic signed [14:0] rpm,
                                            input logic [15:0] budget,
                                            input logic [14:0] volt,
                                            input logic kind);
        t_result         r;
        int unsigned     abs_i;
        int unsigned     spd;
        longint unsigned ie, pa, pb, pc, pd, pred, pq, eff, fixed_pw, var_pw;
        longint unsigned headroom, target, s, mag;
        t_dir            dir;
        bit              reversed;
        if (budget == 0) begin
            r.current = cur;
            r.power   = '0;
            return r;
        end
        abs_i = (cur < 0) ? -int'(cur) : int'(cur);
        spd   = (rpm < 0) ? -int'(rpm) : int'(rpm);
        ie    = (longint'(abs_i) * decay_gain(spd) + 128) >> 8;
        pa    = (ie * spd * PW_K0[kind] + (64'd1 << 31)) >> 32;
        pb    = (longint'(spd) * PW_K1[kind] + (64'd1 << 15)) >> 16;
        pc    = (ie * ie * PW_K2[kind] + (64'd1 << 39)) >> 40;
        pd    = PW_K3[kind];
        pred  = pa + pb + pc + pd;
        pq    = (pred + 128) >> 8;
        r.power = (pq > 65535) ? 16'hffff : pq[15:0];

        dir = (cur > 50) ? DIR_POS : ((cur < -50) ? DIR_NEG : DIR_NONE);
        reversed = heading[kind] != DIR_NONE && dir != DIR_NONE && heading[kind] != dir;
        heading[kind] = dir;

        eff = longint'(budget) << 8;
        if (reversed) begin
            eff = longint'(budget) << 5;
            if (eff < 196608) eff = 196608;
        end

        s = (ratio_q15[kind] > UNITY) ? UNITY : ratio_q15[kind];
        if (pred <= eff) begin
            s = UNITY - ((UNITY - s) * 7) / 10;
        end else if (s < 6554 && 2 * longint'(volt) * volt >= 590490000) begin
            // full supercap: creep back up
            s = (s * 21) / 20;
            if (s > UNITY) s = UNITY;
        end else begin
            fixed_pw = pb + pd;
            var_pw   = pa + pc;
            headroom = (eff > fixed_pw) ? eff - fixed_pw : 0;
            if (var_pw == 0 || headroom >= var_pw) target = UNITY;
            else target = floor_sqrt((headroom << 30) / var_pw);
            if (target > UNITY) target = UNITY;
            if (target < 1638) target = 1638;
            s = (s + target + 1) >> 1;
            if (s > UNITY) s = UNITY;
            if (s < 328) s = 328;
        end
        ratio_q15[kind] = s;

        mag = (longint'(abs_i) * s + 16384) >> 15;
        r.current = (cur < 0) ? -mag[15:0] : mag[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_checked);
        mismatches++;
    endtask

    // one command transfer; the prediction is made when it is accepted
    task automatic send_command(input logic signed [15:0] cur, input logic signed [14:0] rpm,
                                input logic [15:0] budget, input logic [14:0] volt,
                                input logic kind);
        if (idling_on && $urandom_range(99) < 29) begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        cmd.valid          <= 1'b1;
        cmd.target_current <= cur;
        cmd.shaft_speed    <= rpm;
        cmd.power_budget   <= budget;
        cmd.cap_voltage_mv <= volt;
        cmd.motor_kind     <= kind;
        do @(posedge i_clk); while (!(cmd.valid && cmd.ready));
        pending_results.push_back(limit_power(cur, rpm, budget, volt, kind));
        commands_sent++;
    endtask

    task automatic finish_commands();
        cmd.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver side: random stalls plus long hold-offs on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= !(idling_on && $urandom_range(99) < 29);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfers", results_checked + 1, commands_sent);
            end else begin
                want = pending_results.pop_front();
                if (res.limited_current !== want.current)
                    report_mismatch("limited_current", res.limited_current, want.current);
                if (res.predicted_power !== want.power)
                    report_mismatch("predicted_power", res.predicted_power, want.power);
            end
            results_checked++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_extremes();
        logic signed [15:0] cur_set [4] = '{16'sh8000, 16'sh7fff, 16'sd51, -16'sd51};
        logic signed [14:0] rpm_set [6] = '{15'sd0, 15'sd5000, 15'sd5001,
                                            15'sh3fff, 15'sh4000, -15'sd50};
        for (int i = 0; i < 6; i++)
            send_command(cur_set[i % 4], rpm_set[i], 16'hffff, 15'd24300, i[0]);
        send_command(16'sh8000, 15'sh4000, 16'd0, 15'h7fff, 1'b0);     // disabled budget
        send_command(16'sd50, -15'sd51, 16'd1, 15'd0, 1'b1);            // inside deadband
        send_command(16'sh7fff, 15'sh3fff, 16'd1, 15'd30000, 1'b0);
    endtask

    task automatic test_reversal();
        send_command(16'sd20000, 15'sd3000, 16'd2000, 15'd10000, 1'b1);
        send_command(-16'sd20000, 15'sd3000, 16'd2000, 15'd10000, 1'b1);
        send_command(16'sd20000, -15'sd3000, 16'd100, 15'd10000, 1'b1);  // reversal floor
        send_command(16'sd0, 15'sd3000, 16'd100, 15'd10000, 1'b1);
    endtask

    task automatic test_forced_recovery();
        // drive the ratio low, then a full supercap lifts it
        for (int i = 0; i < 6; i++)
            send_command(16'sh7fff, 15'sd3000, 16'd1, 15'd1000, 1'b1);
        for (int i = 0; i < 4; i++)
            send_command(16'sh7fff, 15'sd3000, 16'd1, 15'(17183 + i * 4000), 1'b1);
    endtask

    task automatic test_backpressure();
        idling_on = 1'b0;
        hold_requests++;
        for (int i = 0; i < 8; i++)
            send_command(16'($urandom), 15'($urandom), 16'($urandom_range(3000, 1)),
                         15'($urandom), 1'($urandom));
        idling_on = 1'b1;
    endtask

    task automatic random_command(input bit is_noise, input logic kind,
                                  input logic signed [14:0] rpm_base,
                                  input int budget_class, input logic [14:0] volt);
        logic signed [15:0] cur;
        logic [15:0]        budget;
        logic signed [14:0] rpm;
        if (is_noise) begin
            send_command(16'($urandom), 15'($urandom), 16'($urandom), 15'($urandom),
                         1'($urandom));
            return;
        end
        cur = 16'($urandom);
        if ($urandom_range(9) == 0) cur = 16'($urandom_range(100) - 50);
        rpm = 15'(rpm_base + $urandom_range(200) - 100);
        case (budget_class)
            0: budget = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(800, 1));
            1: budget = 16'($urandom_range(12000, 800));
            default: budget = 16'($urandom);
        endcase
        send_command(cur, rpm, budget, volt, kind);
    endtask

    task automatic test_random(input int count);
        int               sent;
        int               burst;
        logic             kind;
        logic signed [14:0] rpm_base;
        int               budget_class;
        logic [14:0]      volt;
        sent = 0;
        while (sent < count) begin
            kind = 1'($urandom);
            case ($urandom_range(3))
                0: rpm_base = 15'($urandom_range(5400, 4600));
                1: rpm_base = 15'($urandom_range(1500));
                default: rpm_base = 15'($urandom);
            endcase
            if ($urandom_range(1)) rpm_base = -rpm_base;
            budget_class = $urandom_range(2);
            volt = $urandom_range(1) ? 15'($urandom_range(30000, 16000)) : 15'($urandom);
            burst = $urandom_range(12, 3);
            for (int i = 0; i < burst && sent < count; i++) begin
                random_command($urandom_range(9) == 0, kind, rpm_base, budget_class, volt);
                sent++;
            end
        end
    endtask

    initial begin
        mismatches      = 0;
        commands_sent   = 0;
        results_checked = 0;
        hold_requests   = 0;
        idle_cycles     = 0;
        idling_on       = 1'b1;
        for (int k = 0; k < 2; k++) begin
            ratio_q15[k] = UNITY;
            heading[k]   = DIR_NONE;
        end
        i_rst_n            <= 1'b0;
        cmd.valid          <= 1'b0;
        cmd.target_current <= '0;
        cmd.shaft_speed    <= '0;
        cmd.power_budget   <= '0;
        cmd.cap_voltage_mv <= '0;
        cmd.motor_kind     <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_reversal();
        test_forced_recovery();
        test_backpressure();
        test_random(700);
        idling_on = 1'b0;       // stretch with no idling on either side
        test_random(400);
        idling_on = 1'b1;
        test_backpressure();
        test_random(830);
        finish_commands();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        $display("covered %0d commands over both motor kinds: disabled budget, reversals,",
                 commands_sent);
        $display("forced recovery, limiting, knee speeds and long result hold-offs");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/mpl_pkg.sv
rtl/mpl_if.sv
rtl/mpl_mul.sv
rtl/motor_power_limiter.sv
rtl/mpl_checker.sv
tb/tb.sv
